// ===== hw/rtl/hpt_pkg.sv =====
// Package for the homogeneous point transform.
// Holds transaction payload types, the pipeline control struct and status codes.
// No dependencies.
`default_nettype none
package hpt_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int HALF_W   = 32;
    localparam int IDX_W    = 3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WZERO = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic [1:0]         status;
    } t_point_out;

    typedef struct packed {
        logic       valid;
        logic       wzero;
        logic [2:0] neg;
        logic [2:0] over;
    } t_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/hpt_front.sv =====
// Front end of the point transform: products, sums, magnitudes, range check.
// Four registered stages feeding the divider chain. Depends on hpt_pkg.
`default_nettype none
module hpt_front #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  hpt_pkg::t_point_in   i_point,
    input  wire [16*CW-1:0]      i_coef,
    output hpt_pkg::t_ctl        o_ctl,
    output logic [2*CW+1:0]      o_den,
    output logic [3*(2*CW+2)-1:0] o_rem,
    output logic [3*CW-1:0]      o_nlo
);
    localparam int PW = 2 * CW;
    localparam int S  = 2 * CW + 2;
    localparam int K  = CW;
    localparam int NW = S + FB;
    localparam int HW = NW - K;

    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] c [16];

    logic signed [PW-1:0] r_prod [12];
    logic signed [CW-1:0] r_trans [4];
    logic signed [S-1:0]  r_sum [4];
    logic [S-1:0]         r_mag [3];
    logic [S-1:0]         r_wmag;
    logic [2:0]           r_neg;
    logic                 r_wz;
    logic [2:0]           r_v;
    hpt_pkg::t_ctl        r_ctl;
    logic [S-1:0]         r_den;
    logic [S-1:0]         r_rem [3];
    logic [K-1:0]         r_nlo [3];

    always_comb begin
        p[0] = i_point.point_x[CW-1:0];
        p[1] = i_point.point_y[CW-1:0];
        p[2] = i_point.point_z[CW-1:0];
        for (int i = 0; i < 16; i++) begin
            c[i] = i_coef[i*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        logic [HW-1:0] hi;
        if (!i_rst_n) begin
            r_v       <= '0;
            r_ctl.valid <= 1'b0;
        end else begin
            r_v       <= {r_v[1:0], i_valid};
            r_ctl.valid <= r_v[2];
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 4; j++) begin
                r_prod[k*4+j] <= PW'(p[k]) * PW'(c[k*4+j]);
            end
        end
        for (int j = 0; j < 4; j++) begin
            r_trans[j] <= c[12+j];
            r_sum[j]   <= S'(r_prod[j]) + S'(r_prod[4+j]) + S'(r_prod[8+j])
                          + (S'(r_trans[j]) <<< FB);
        end
        for (int j = 0; j < 3; j++) begin
            r_mag[j] <= r_sum[j][S-1] ? -r_sum[j] : r_sum[j];
            r_neg[j] <= r_sum[j][S-1] ^ r_sum[3][S-1];
        end
        r_wmag <= r_sum[3][S-1] ? -r_sum[3] : r_sum[3];
        r_wz   <= (r_sum[3] == '0);
        r_ctl.wzero <= r_wz;
        r_ctl.neg   <= r_neg;
        r_den       <= r_wmag;
        for (int j = 0; j < 3; j++) begin
            num = {r_mag[j], {FB{1'b0}}};
            hi  = num[NW-1:K];
            r_ctl.over[j] <= ({{(NW-S){1'b0}}, r_wmag} <= NW'(hi));
            r_rem[j] <= S'(hi);
            r_nlo[j] <= num[K-1:0];
        end
    end

    always_comb begin
        o_ctl = r_ctl;
        o_den = r_den;
        for (int j = 0; j < 3; j++) begin
            o_rem[j*S +: S] = r_rem[j];
            o_nlo[j*K +: K] = r_nlo[j];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hpt_cell.sv =====
// One restoring-division cell: one quotient bit for each of three lanes.
// Registered; hands remainder, numerator bits and quotient on. Depends on hpt_pkg.
`default_nettype none
module hpt_cell #(
    parameter int CW = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  hpt_pkg::t_ctl          i_ctl,
    input  wire [2*CW+1:0]         i_den,
    input  wire [3*(2*CW+2)-1:0]   i_rem,
    input  wire [3*CW-1:0]         i_nlo,
    input  wire [3*CW-1:0]         i_q,
    output hpt_pkg::t_ctl          o_ctl,
    output logic [2*CW+1:0]        o_den,
    output logic [3*(2*CW+2)-1:0]  o_rem,
    output logic [3*CW-1:0]        o_nlo,
    output logic [3*CW-1:0]        o_q
);
    localparam int S = 2 * CW + 2;
    localparam int K = CW;

    logic [3*S-1:0] n_rem;
    logic [3*K-1:0] n_nlo;
    logic [3*K-1:0] n_q;

    always_comb begin
        logic [S:0] t;
        logic [S:0] d;
        logic       ge;
        for (int j = 0; j < 3; j++) begin
            t  = {i_rem[j*S +: S], i_nlo[j*K + K - 1]};
            d  = {1'b0, i_den};
            ge = (t >= d);
            n_rem[j*S +: S] = ge ? S'(t - d) : t[S-1:0];
            n_nlo[j*K +: K] = {i_nlo[j*K +: K-1], 1'b0};
            n_q[j*K +: K]   = {i_q[j*K +: K-1], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
        end
        o_ctl.wzero <= i_ctl.wzero;
        o_ctl.neg   <= i_ctl.neg;
        o_ctl.over  <= i_ctl.over;
        o_den       <= i_den;
        o_rem       <= n_rem;
        o_nlo       <= n_nlo;
        o_q         <= n_q;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/homogeneous_point_transform.sv =====
// 4x4 matrix point transform with perspective divide, signed fixed point.
// Stages from start to o_valid: 4 front stages, CW division
// cells, one output stage; throughput one transaction per cycle, busy stays low.
// The division chain is one cell per quotient bit. Results cannot be stalled.
// Synchronous active-low reset clears valid bits and loads the identity matrix.
`default_nettype none
module homogeneous_point_transform #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  hpt_pkg::t_point_in          i_point,
    input  wire                         i_cfg_we,
    input  wire [hpt_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire [hpt_pkg::REG_W-1:0]    i_cfg_data,
    output logic                        o_valid,
    output hpt_pkg::t_point_out         o_result
);
    localparam int S = 2 * CW + 2;
    localparam int K = CW;
    localparam logic [hpt_pkg::REG_W-1:0] ONE = hpt_pkg::REG_W'(1) << FB;

    logic [hpt_pkg::REG_W-1:0] r_cfg [hpt_pkg::NUM_REGS];
    logic [16*CW-1:0]          coef;

    hpt_pkg::t_ctl  c_ctl [K+1];
    logic [S-1:0]   c_den [K+1];
    logic [3*S-1:0] c_rem [K+1];
    logic [3*K-1:0] c_nlo [K+1];
    logic [3*K-1:0] c_q   [K+1];

    logic               r_valid;
    hpt_pkg::t_point_out r_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= ONE;
            r_cfg[1] <= '0;
            r_cfg[2] <= ONE << hpt_pkg::HALF_W;
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= ONE;
            r_cfg[6] <= '0;
            r_cfg[7] <= ONE << hpt_pkg::HALF_W;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[(r*4+c)*CW +: CW] = r_cfg[r*2 + c/2][(c%2)*hpt_pkg::HALF_W +: CW];
            end
        end
    end

    hpt_front #(.CW(CW), .FB(FB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_point (i_point),
        .i_coef  (coef),
        .o_ctl   (c_ctl[0]),
        .o_den   (c_den[0]),
        .o_rem   (c_rem[0]),
        .o_nlo   (c_nlo[0])
    );
    assign c_q[0] = '0;

    for (genvar g = 0; g < K; g++) begin : g_cell
        hpt_cell #(.CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[g]),
            .i_den   (c_den[g]),
            .i_rem   (c_rem[g]),
            .i_nlo   (c_nlo[g]),
            .i_q     (c_q[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_den   (c_den[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_nlo   (c_nlo[g+1]),
            .o_q     (c_q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= c_ctl[K].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        hpt_pkg::t_ctl      ctl;
        logic [K-1:0]       q;
        logic [K-1:0]       lim;
        logic [K-1:0]       mag;
        logic signed [CW-1:0] val [3];
        logic               sat;
        logic               any;
        ctl = c_ctl[K];
        any = 1'b0;
        for (int j = 0; j < 3; j++) begin
            q   = c_q[K][j*K +: K];
            lim = (K'(1) << (CW-1)) - K'(!ctl.neg[j]);
            sat = ctl.over[j] | (q > lim);
            mag = sat ? lim : q;
            val[j] = ctl.neg[j] ? -mag : mag;
            any = any | sat;
        end
        if (ctl.wzero) begin
            r_res.result_x <= '0;
            r_res.result_y <= '0;
            r_res.result_z <= '0;
            r_res.status   <= hpt_pkg::ST_WZERO;
        end else begin
            r_res.result_x <= 32'(val[0]);
            r_res.result_y <= 32'(val[1]);
            r_res.result_z <= 32'(val[2]);
            r_res.status   <= any ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule
`default_nettype wire
